>>> hdl/emrd_pkg.sv
package emrd_pkg;

	// Frame layout and CRC constants.
	localparam int unsigned FRAME_BYTES      = 25;
	localparam int unsigned FIRST_FIELD_BYTE = 3;
	localparam int unsigned FIELD_BYTES      = 20;
	localparam logic [15:0] CRC_INIT         = 16'hFFFF;
	localparam logic [15:0] CRC_POLY         = 16'hA001;
	localparam int unsigned POS_W            = 5;
	localparam int unsigned QUEUE_DEPTH      = 4;
	localparam int unsigned QPTR_W           = 2;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_CRC   = 2'd1,
		STATUS_SHORT = 2'd2
	} status_t;

	// One classified byte, handed from the front to the back.
	typedef struct packed {
		logic [7:0]       rx_byte;
		logic [POS_W-1:0] pos;
		logic             last;
		logic             is_short;
	} cmd_t;

	// One decoded reply.
	typedef struct packed {
		status_t     status;
		logic [15:0] voltage;
		logic [31:0] current;
		logic [31:0] power;
		logic [31:0] energy;
		logic [15:0] frequency;
		logic [15:0] power_factor;
		logic [15:0] alarm_word;
	} result_t;

	// CRC-16/MODBUS update by one byte, bit by bit.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> hdl/emrd_front.sv
module emrd_front import emrd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	input  logic       frame_end,
	output logic       cmd_push,
	output cmd_t       cmd,
	input  logic       cmd_full
);

	logic [POS_W-1:0] pos_q;
	logic             skip_q;
	logic             accept;
	logic [POS_W:0]   pos_next;
	logic             at_limit;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	// Classify the byte: its position, and whether it closes the frame.
	assign pos_next = {1'b0, pos_q} + {{POS_W{1'b0}}, 1'b1};
	assign at_limit = (pos_next >= (POS_W + 1)'(FRAME_BYTES));

	always_comb begin
		cmd.rx_byte  = rx_byte;
		cmd.pos      = pos_q;
		cmd.last     = at_limit || frame_end;
		cmd.is_short = !at_limit;
	end

	assign cmd_push = accept && !skip_q;

	// Position counter and the skip flag for bytes after an early result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			skip_q <= 1'b0;
		end else if (accept) begin
			if (skip_q) begin
				if (frame_end) begin
					skip_q <= 1'b0;
				end
			end else if (at_limit || frame_end) begin
				pos_q  <= '0;
				skip_q <= !frame_end;
			end else begin
				pos_q <= pos_next[POS_W-1:0];
			end
		end
	end

endmodule

>>> hdl/emrd_queue.sv
module emrd_queue import emrd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  cmd_t wr_data,
	input  logic pop,
	output logic empty,
	output cmd_t rd_data
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage entries.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/emrd_back.sv
module emrd_back import emrd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  logic    cmd_empty,
	output logic    cmd_pop,
	output logic    empty,
	input  logic    pop,
	output result_t res
);

	logic [15:0]      tail_crc_q;
	logic [15:0]      tail_q;
	logic [15:0]      voltage_q;
	logic [31:0]      current_q;
	logic [31:0]      power_q;
	logic [31:0]      energy_q;
	logic [15:0]      frequency_q;
	logic [15:0]      factor_q;
	logic [15:0]      alarm_q;
	logic             out_valid_q;
	result_t          res_q;

	logic             take;
	logic [15:0]      tail_crc_n;
	logic [15:0]      tail_n;
	logic [15:0]      voltage_n;
	logic [31:0]      current_n;
	logic [31:0]      power_n;
	logic [31:0]      energy_n;
	logic [15:0]      frequency_n;
	logic [15:0]      factor_n;
	logic [15:0]      alarm_n;
	logic [POS_W-1:0] idx;
	logic [3:0]       word;
	logic             hi;
	logic             in_fields;
	status_t          status_n;

	// A closing beat needs the output register free or being emptied.
	assign take    = !cmd_empty && (!cmd.last || !out_valid_q || pop);
	assign cmd_pop = take;
	assign empty   = !out_valid_q;
	assign res     = res_q;

	// CRC over all but the last two bytes, and the two-byte tail itself.
	assign tail_crc_n = (cmd.pos >= POS_W'(2)) ? crc_feed(tail_crc_q, tail_q[7:0]) : tail_crc_q;
	assign tail_n     = {cmd.rx_byte, tail_q[15:8]};

	// Field capture: big-endian words, 32-bit values low word first.
	assign in_fields = (cmd.pos >= POS_W'(FIRST_FIELD_BYTE))
		&& (cmd.pos < POS_W'(FIRST_FIELD_BYTE + FIELD_BYTES));
	assign idx  = cmd.pos - POS_W'(FIRST_FIELD_BYTE);
	assign word = idx[4:1];
	assign hi   = !idx[0];

	always_comb begin
		voltage_n   = voltage_q;
		current_n   = current_q;
		power_n     = power_q;
		energy_n    = energy_q;
		frequency_n = frequency_q;
		factor_n    = factor_q;
		alarm_n     = alarm_q;
		if (in_fields) begin
			case (word)
				4'd0: if (hi) voltage_n[15:8] = cmd.rx_byte; else voltage_n[7:0] = cmd.rx_byte;
				4'd1: if (hi) current_n[15:8] = cmd.rx_byte; else current_n[7:0] = cmd.rx_byte;
				4'd2: if (hi) current_n[31:24] = cmd.rx_byte; else current_n[23:16] = cmd.rx_byte;
				4'd3: if (hi) power_n[15:8] = cmd.rx_byte; else power_n[7:0] = cmd.rx_byte;
				4'd4: if (hi) power_n[31:24] = cmd.rx_byte; else power_n[23:16] = cmd.rx_byte;
				4'd5: if (hi) energy_n[15:8] = cmd.rx_byte; else energy_n[7:0] = cmd.rx_byte;
				4'd6: if (hi) energy_n[31:24] = cmd.rx_byte; else energy_n[23:16] = cmd.rx_byte;
				4'd7: if (hi) frequency_n[15:8] = cmd.rx_byte; else frequency_n[7:0] = cmd.rx_byte;
				4'd8: if (hi) factor_n[15:8] = cmd.rx_byte; else factor_n[7:0] = cmd.rx_byte;
				default: if (hi) alarm_n[15:8] = cmd.rx_byte; else alarm_n[7:0] = cmd.rx_byte;
			endcase
		end
	end

	// Status of a closing beat.
	always_comb begin
		if (cmd.is_short) begin
			status_n = STATUS_SHORT;
		end else if (tail_n == tail_crc_n) begin
			status_n = STATUS_OK;
		end else begin
			status_n = STATUS_CRC;
		end
	end

	// Frame state: updated per byte, cleared after each result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_crc_q  <= CRC_INIT;
			tail_q      <= '0;
			voltage_q   <= '0;
			current_q   <= '0;
			power_q     <= '0;
			energy_q    <= '0;
			frequency_q <= '0;
			factor_q    <= '0;
			alarm_q     <= '0;
		end else if (take) begin
			if (cmd.last) begin
				tail_crc_q  <= CRC_INIT;
				tail_q      <= '0;
				voltage_q   <= '0;
				current_q   <= '0;
				power_q     <= '0;
				energy_q    <= '0;
				frequency_q <= '0;
				factor_q    <= '0;
				alarm_q     <= '0;
			end else begin
				tail_crc_q  <= tail_crc_n;
				tail_q      <= tail_n;
				voltage_q   <= voltage_n;
				current_q   <= current_n;
				power_q     <= power_n;
				energy_q    <= energy_n;
				frequency_q <= frequency_n;
				factor_q    <= factor_n;
				alarm_q     <= alarm_n;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && cmd.last) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload; values are zero unless the frame checked out.
	always_ff @(posedge clk) begin
		if (take && cmd.last) begin
			res_q.status       <= status_n;
			res_q.voltage      <= (status_n == STATUS_OK) ? voltage_n : '0;
			res_q.current      <= (status_n == STATUS_OK) ? current_n : '0;
			res_q.power        <= (status_n == STATUS_OK) ? power_n : '0;
			res_q.energy       <= (status_n == STATUS_OK) ? energy_n : '0;
			res_q.frequency    <= (status_n == STATUS_OK) ? frequency_n : '0;
			res_q.power_factor <= (status_n == STATUS_OK) ? factor_n : '0;
			res_q.alarm_word   <= (status_n == STATUS_OK) ? alarm_n : '0;
		end
	end

endmodule

>>> hdl/energy_meter_response_decoder_core.sv
// Channel   Handshake            Payload
// input     push / full          rx_byte[7:0], frame_end
// result    empty / pop          status[1:0], voltage, current, power, energy,
//                                frequency, power_factor, alarm_word
//
// One byte beat is taken per cycle while full is low. A byte goes through the
// front stage, a four-entry queue and the back stage; the back stage registers
// a result when it takes the beat closing the frame from the queue. The back
// stage holds a closing beat while an earlier result waits unpopped, and full
// rises once that beat and three more beats fill the queue. Reset is
// asynchronous and clears all frame state; no clearing pass is needed.
module energy_meter_response_decoder_core import emrd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	input  logic        frame_end,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [15:0] voltage,
	output logic [31:0] current,
	output logic [31:0] power,
	output logic [31:0] energy,
	output logic [15:0] frequency,
	output logic [15:0] power_factor,
	output logic [15:0] alarm_word
);

	cmd_t    cmd_in;
	cmd_t    cmd_out;
	logic    cmd_push;
	logic    cmd_full;
	logic    cmd_pop;
	logic    cmd_empty;
	result_t res;

	// Front: accepts beats and classifies each byte.
	emrd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.rx_byte   (rx_byte),
		.frame_end (frame_end),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.cmd_full  (cmd_full)
	);

	// Queue between front and back.
	emrd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.full    (cmd_full),
		.wr_data (cmd_in),
		.pop     (cmd_pop),
		.empty   (cmd_empty),
		.rd_data (cmd_out)
	);

	// Back: CRC, field capture and result register.
	emrd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign status       = res.status;
	assign voltage      = res.voltage;
	assign current      = res.current;
	assign power        = res.power;
	assign energy       = res.energy;
	assign frequency    = res.frequency;
	assign power_factor = res.power_factor;
	assign alarm_word   = res.alarm_word;

endmodule
